// ===== rtl/swbl_pkg.sv =====
// shared types, constants and level table for the single-wire backlight controller
// no dependencies
package swbl_pkg;

  localparam int LEVEL_W   = 5;
  localparam int BRIGHT_W  = 8;
  localparam int FUNC_W    = 2;
  localparam int ACTION_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  // pulse counter holds up to 2^LEVEL_W pulses
  localparam int CNT_W = LEVEL_W + 1;

  localparam int BUILTIN_ENTRIES = 17;
  localparam int TABLE_ENTRIES   = 17;
  localparam int USED_ENTRIES    = (TABLE_ENTRIES < 1) ? 1 :
                                   (TABLE_ENTRIES > BUILTIN_ENTRIES) ? BUILTIN_ENTRIES :
                                   TABLE_ENTRIES;

  localparam int JOB_DEPTH_DEFAULT = 4;

  localparam logic [BRIGHT_W-1:0] FULL_BRIGHTNESS = 8'd255;

  localparam logic [BRIGHT_W-1:0] DIM_THRESHOLD_RESET = 8'd16;
  localparam logic [LEVEL_W-1:0]  DIM_LEVEL_RESET     = 5'd31;

  localparam logic [FUNC_W-1:0] FUNC_SET     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESUME  = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_ENABLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PULSE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_OFF    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SETTLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL     = 1'd1;

  localparam logic [BRIGHT_W-1:0] LEVEL_THRESH [BUILTIN_ENTRIES] = '{
    8'd30, 8'd35, 8'd45, 8'd60, 8'd75, 8'd90, 8'd105, 8'd120, 8'd135,
    8'd150, 8'd165, 8'd180, 8'd195, 8'd210, 8'd225, 8'd230, 8'd255
  };

  localparam logic [LEVEL_W-1:0] LEVEL_TUNE [BUILTIN_ENTRIES] = '{
    5'd30, 5'd29, 5'd28, 5'd26, 5'd24, 5'd23, 5'd22, 5'd21, 5'd20,
    5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd6
  };

  // one run of line actions, as handed from front to back
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               enable;
  } job_t;

endpackage

// ===== rtl/swbl_front.sv =====
// front end: accepts requests, holds config and request state, maps brightness
// to a tune level and queues a run when the level changes; uses swbl_pkg
module swbl_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swbl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [swbl_pkg::FUNC_W-1:0]    func,
  input  logic [swbl_pkg::BRIGHT_W-1:0]  brightness,
  output logic                           job_push,
  output swbl_pkg::job_t                 job_data,
  input  logic                           job_full
);
  import swbl_pkg::*;

  logic [BRIGHT_W-1:0] dim_threshold;
  logic [LEVEL_W-1:0]  dim_level;
  logic [BRIGHT_W-1:0] stored_brightness;
  logic [LEVEL_W-1:0]  current_level;
  logic                suspended;
  logic                line_powered;

  logic                accept;
  logic [BRIGHT_W-1:0] b_sel;
  logic [LEVEL_W-1:0]  scan_level;
  logic [LEVEL_W-1:0]  mapped;
  logic                wants_drive;

  assign cfg_ready = 1'b1;
  assign full      = job_full;
  assign accept    = push && !job_full;

  assign b_sel = (func == FUNC_SET) ? brightness : stored_brightness;

  // first threshold at or above the brightness wins
  always_comb begin
    scan_level = '0;
    for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
      if (b_sel <= LEVEL_THRESH[i]) begin
        scan_level = LEVEL_TUNE[i];
      end
    end
  end

  always_comb begin
    priority if (b_sel == '0) begin
      mapped = '0;
    end else if (b_sel < dim_threshold) begin
      mapped = dim_level;
    end else if (b_sel == FULL_BRIGHTNESS) begin
      mapped = LEVEL_TUNE[USED_ENTRIES-1];
    end else begin
      mapped = scan_level;
    end
  end

  always_comb begin
    unique case (func)
      FUNC_SET:    wants_drive = !suspended;
      FUNC_RESUME: wants_drive = 1'b1;
      default:     wants_drive = 1'b0;
    endcase
  end

  assign job_push        = accept && wants_drive && (mapped != current_level);
  assign job_data.level  = mapped;
  assign job_data.enable = (mapped != '0) && !line_powered;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_threshold     <= DIM_THRESHOLD_RESET;
      dim_level         <= DIM_LEVEL_RESET;
      stored_brightness <= '0;
      current_level     <= '0;
      suspended         <= 1'b0;
      line_powered      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DIM_THRESHOLD: dim_threshold <= cfg_data;
          REG_DIM_LEVEL:     dim_level     <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (func)
          FUNC_SET:     stored_brightness <= brightness;
          FUNC_SUSPEND: suspended         <= 1'b1;
          FUNC_RESUME:  suspended         <= 1'b0;
          default: ;
        endcase
      end
      if (job_push) begin
        current_level <= mapped;
        line_powered  <= (mapped != '0);
      end
    end
  end

`ifndef SYNTHESIS
  a_powered_tracks_level: assert property (@(posedge clk) disable iff (rst)
    line_powered == (current_level != '0))
    else $error("line power flag out of step with level");

  a_level_follows_job: assert property (@(posedge clk) disable iff (rst)
    job_push |=> current_level == $past(job_data.level))
    else $error("level not updated after queued run");

  a_enable_only_when_off: assert property (@(posedge clk) disable iff (rst)
    job_push && job_data.enable |-> !line_powered && job_data.level != '0)
    else $error("enable hold queued while line powered");
`endif

endmodule

// ===== rtl/swbl_job_fifo.sv =====
// small queue of pending runs between front and back
// uses swbl_pkg for the job type
module swbl_job_fifo #(
  parameter int DEPTH = swbl_pkg::JOB_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swbl_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output swbl_pkg::job_t rdata,
  output logic           valid
);
  import swbl_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

  job_t               mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == FULL_CNT);
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/swbl_back.sv =====
// back end: turns a queued run into line actions, one per cycle while pop is high,
// through an output register with empty/pop; uses swbl_pkg
module swbl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  swbl_pkg::job_t                job_data,
  output logic                          job_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [swbl_pkg::ACTION_W-1:0] action,
  output logic [swbl_pkg::LEVEL_W-1:0]  applied_level,
  output logic                          last
);
  import swbl_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PULSE  = 2'd1;
  localparam logic [1:0] ST_SETTLE = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [LEVEL_W-1:0] run_level;
  logic               out_valid;

  logic               advance;
  logic               emit;
  logic [ACTION_W-1:0] emit_action;
  logic [LEVEL_W-1:0] emit_level;
  logic               emit_last;

  // output slot is free or being taken this cycle
  assign advance = !out_valid || pop;
  assign empty   = !out_valid;
  assign job_pop = advance && (state == ST_IDLE) && job_valid;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    emit        = 1'b0;
    emit_action = ACT_SETTLE;
    emit_level  = run_level;
    emit_last   = 1'b0;
    if (advance) begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            emit       = 1'b1;
            emit_level = job_data.level;
            priority if (job_data.level == '0) begin
              emit_action = ACT_OFF;
              state_next  = ST_SETTLE;
            end else if (job_data.enable) begin
              emit_action = ACT_ENABLE;
              cnt_next    = {1'b0, job_data.level} + 1'b1;
              state_next  = ST_PULSE;
            end else begin
              // level+1 pulses in all, one goes out now
              emit_action = ACT_PULSE;
              cnt_next    = {1'b0, job_data.level};
              state_next  = ST_PULSE;
            end
          end
        end
        ST_PULSE: begin
          emit        = 1'b1;
          emit_action = ACT_PULSE;
          cnt_next    = cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state_next = ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          emit        = 1'b1;
          emit_action = ACT_SETTLE;
          emit_last   = 1'b1;
          state_next  = ST_IDLE;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      run_level <= job_data.level;
    end
    if (advance && emit) begin
      action        <= emit_action;
      applied_level <= emit_level;
      last          <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_last_is_settle: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> action == ACT_SETTLE)
    else $error("last flag on an action other than settle");

  a_pulse_count_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_PULSE |-> cnt != '0)
    else $error("pulse state with nothing left to send");

  a_off_means_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_OFF) |-> applied_level == '0)
    else $error("off action with nonzero level");
`endif

endmodule

// ===== rtl/single_wire_backlight_controller_unit.sv =====
// single-wire pulse-count backlight controller, top level
// channels:
//   request queue: push/full with func and brightness; accepted when push && !full
//   result queue: empty/pop with action, applied_level and last; the oldest
//     line action is on the ports while empty is low
//   config: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready
// a request that changes the level becomes a run of 2 to 34 line actions,
// last set on the closing settle; other requests produce nothing
// the first action of a run passes through the run queue and then the back end's output register
// throughput: one action per cycle from the sequencer in the back end while pop is high
//   or no action is on the ports, and the next queued run follows with no
//   gap; requests are taken one per cycle while the run queue (JOB_DEPTH
//   entries) has room
// when pop stays low the current action holds, the sequencer stops, the run
//   queue fills and then full goes high
// reset clears stored brightness, level, suspend and line-power state,
//   empties both queues and loads dim_threshold 16 and dim_level 31
// depends on swbl_pkg, swbl_front, swbl_job_fifo, swbl_back
module single_wire_backlight_controller_unit #(
  parameter int JOB_DEPTH = swbl_pkg::JOB_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swbl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [swbl_pkg::FUNC_W-1:0]     func,
  input  logic [swbl_pkg::BRIGHT_W-1:0]   brightness,
  output logic                            empty,
  input  logic                            pop,
  output logic [swbl_pkg::ACTION_W-1:0]   action,
  output logic [swbl_pkg::LEVEL_W-1:0]    applied_level,
  output logic                            last
);
  import swbl_pkg::*;

  logic job_push;
  job_t job_wdata;
  logic job_full;
  logic job_valid;
  job_t job_rdata;
  logic job_pop;

  swbl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .func       (func),
    .brightness (brightness),
    .job_push   (job_push),
    .job_data   (job_wdata),
    .job_full   (job_full)
  );

  swbl_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .valid (job_valid)
  );

  swbl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_data      (job_rdata),
    .job_pop       (job_pop),
    .empty         (empty),
    .pop           (pop),
    .action        (action),
    .applied_level (applied_level),
    .last          (last)
  );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for single_wire_backlight_controller_unit: queued requests,
// a line action predictor with its own level table, random push/pop idling and a stall
// depends on swbl_pkg and the controller rtl
module testbench;
  import swbl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STEPS        = 17;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 16;

  localparam logic [BRIGHT_W-1:0] STEP_BRIGHT [STEPS] = '{
    8'd30, 8'd35, 8'd45, 8'd60, 8'd75, 8'd90, 8'd105, 8'd120, 8'd135,
    8'd150, 8'd165, 8'd180, 8'd195, 8'd210, 8'd225, 8'd230, 8'd255
  };
  localparam logic [LEVEL_W-1:0] STEP_TUNE [STEPS] = '{
    5'd30, 5'd29, 5'd28, 5'd26, 5'd24, 5'd23, 5'd22, 5'd21, 5'd20,
    5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd6
  };

  // register settings walked through after the opening part, the last one random
  localparam int SETTINGS_N = 6;
  localparam logic [BRIGHT_W-1:0] THRESH_SET [SETTINGS_N-1] = '{
    8'd0, 8'd255, 8'd255, 8'd200, 8'd1
  };
  localparam logic [LEVEL_W-1:0] DIM_SET [SETTINGS_N-1] = '{
    5'd0, 5'd0, 5'd31, 5'd17, 5'd5
  };

  typedef struct packed {
    logic [FUNC_W-1:0]   code;
    logic [BRIGHT_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [LEVEL_W-1:0]  lvl;
    logic                fin;
  } line_action_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [FUNC_W-1:0] func = '0;
  logic [BRIGHT_W-1:0] brightness = '0;
  logic empty;
  logic pop = 1'b0;
  logic [ACTION_W-1:0] action;
  logic [LEVEL_W-1:0] applied_level;
  logic last;

  single_wire_backlight_controller_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .func(func), .brightness(brightness),
    .empty(empty), .pop(pop), .action(action), .applied_level(applied_level), .last(last)
  );

  always #10 clk = ~clk;

  request_t     pending_requests [$];
  line_action_t expected_actions [$];

  // controller state as predicted
  logic [BRIGHT_W-1:0] dim_threshold = DIM_THRESHOLD_RESET;
  logic [LEVEL_W-1:0]  dim_level     = DIM_LEVEL_RESET;
  logic [BRIGHT_W-1:0] held_brightness = '0;
  logic [LEVEL_W-1:0]  level_now = '0;
  logic                suspended = 1'b0;
  logic                line_on = 1'b0;

  int mismatches = 0;
  int actions_seen = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  bit sending = 1'b0;
  bit held = 1'b0;
  logic hold_request = 1'b0;
  request_t next_req;
  line_action_t want;

  function automatic logic [LEVEL_W-1:0] tune_for(input logic [BRIGHT_W-1:0] b);
    int i;
    if (b == '0) return '0;
    if (b < dim_threshold) return dim_level;
    if (b == FULL_BRIGHTNESS) return STEP_TUNE[STEPS-1];
    for (i = 0; i < STEPS; i++)
      if (b <= STEP_BRIGHT[i]) return STEP_TUNE[i];
    return '0;
  endfunction

  task automatic queue_line_run(input logic [LEVEL_W-1:0] lvl);
    int i;
    if (lvl == level_now) return;
    if (lvl == '0) begin
      expected_actions.push_back('{ACT_OFF, lvl, 1'b0});
      line_on = 1'b0;
    end else begin
      if (!line_on) begin
        expected_actions.push_back('{ACT_ENABLE, lvl, 1'b0});
        line_on = 1'b1;
      end
      // level+1 pulses
      for (i = 0; i <= lvl; i++) expected_actions.push_back('{ACT_PULSE, lvl, 1'b0});
    end
    expected_actions.push_back('{ACT_SETTLE, lvl, 1'b1});
    level_now = lvl;
  endtask

  task automatic predict_request(input request_t r);
    case (r.code)
      FUNC_SET: begin
        held_brightness = r.value;
        if (!suspended) queue_line_run(tune_for(held_brightness));
      end
      FUNC_SUSPEND: suspended = 1'b1;
      FUNC_RESUME: begin
        suspended = 1'b0;
        queue_line_run(tune_for(held_brightness));
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what);
    if (mismatches < 100) $display("mismatch at action %0d: %s", actions_seen, what);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_request('{func, brightness});
        sending = 1'b0;
        if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, 6);
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          push <= 1'b1;
          func <= next_req.code;
          brightness <= next_req.value;
          sending = 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // line action monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_actions.size() == 0) begin
          report($sformatf("unexpected action %0d level %0d", action, applied_level));
        end else begin
          want = expected_actions.pop_front();
          if (action !== want.act)
            report($sformatf("action %0d, want %0d", action, want.act));
          if (applied_level !== want.lvl)
            report($sformatf("applied_level %0d, want %0d", applied_level, want.lvl));
          if (last !== want.fin)
            report($sformatf("last %0d, want %0d", last, want.fin));
        end
        actions_seen++;
        if ($urandom_range(0, 19) == 0) recv_steady = !recv_steady;
        recv_gap = recv_steady ? 0 : $urandom_range(0, 6);
      end
      if (hold_request && !held) begin
        held = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DIM_THRESHOLD) dim_threshold = data;
    else dim_level = data[LEVEL_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || sending || expected_actions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int k;
    int pick;
    logic [BRIGHT_W-1:0] b;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: b = '0;
        1: b = FULL_BRIGHTNESS;
        2: b = BRIGHT_W'(dim_threshold + $urandom_range(0, 2) - 1);
        default: b = BRIGHT_W'($urandom_range(0, 255));
      endcase
      if (pick < 8) pending_requests.push_back('{FUNC_SUSPEND, b});
      else if (pick < 18) pending_requests.push_back('{FUNC_RESUME, b});
      else if (pick < 21) pending_requests.push_back('{FUNC_UNUSED, b});
      else pending_requests.push_back('{FUNC_SET, b});
    end
  endtask

  initial begin
    int p;
    logic [BRIGHT_W-1:0] thr;
    logic [LEVEL_W-1:0] dim;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // opening part under reset register values
    pending_requests.push_back('{FUNC_SET, 8'd0});
    pending_requests.push_back('{FUNC_SET, 8'd255});
    pending_requests.push_back('{FUNC_SET, 8'd255});
    pending_requests.push_back('{FUNC_SET, 8'd30});
    pending_requests.push_back('{FUNC_SET, 8'd31});
    pending_requests.push_back('{FUNC_SET, 8'd16});
    pending_requests.push_back('{FUNC_SET, 8'd15});
    pending_requests.push_back('{FUNC_SET, 8'd0});
    // line off then dim level 31: longest run
    pending_requests.push_back('{FUNC_SET, 8'd1});
    pending_requests.push_back('{FUNC_SUSPEND, 8'd0});
    pending_requests.push_back('{FUNC_SET, 8'd230});
    pending_requests.push_back('{FUNC_SET, 8'd231});
    pending_requests.push_back('{FUNC_RESUME, 8'd255});
    pending_requests.push_back('{FUNC_SUSPEND, 8'd255});
    pending_requests.push_back('{FUNC_SET, 8'd0});
    pending_requests.push_back('{FUNC_RESUME, 8'd0});
    pending_requests.push_back('{FUNC_RESUME, 8'd0});
    pending_requests.push_back('{FUNC_UNUSED, 8'hAA});
    pending_requests.push_back('{FUNC_UNUSED, 8'h55});
    pending_requests.push_back('{FUNC_SET, 8'd254});
    pending_requests.push_back('{FUNC_SET, 8'd128});
    pending_requests.push_back('{FUNC_SET, 8'd200});
    pending_requests.push_back('{FUNC_SET, 8'd100});
    wait_idle();

    for (p = 0; p < SETTINGS_N; p++) begin
      thr = (p < SETTINGS_N - 1) ? THRESH_SET[p] : BRIGHT_W'($urandom_range(0, 255));
      dim = (p < SETTINGS_N - 1) ? DIM_SET[p] : LEVEL_W'($urandom_range(0, 31));
      write_reg(REG_DIM_THRESHOLD, thr);
      // upper data bits are don't-care for the level register
      write_reg(REG_DIM_LEVEL, {3'($urandom_range(0, 7)), dim});
      // stall results early on so the request side backs up
      if (p == 0) hold_request <= 1'b1;
      random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swbl_pkg.sv
rtl/swbl_front.sv
rtl/swbl_job_fifo.sv
rtl/swbl_back.sv
rtl/single_wire_backlight_controller_unit.sv
test/testbench.sv
